/* rtl/note_arpeggiator_defines.svh */
// Assertion macros for the note arpeggiator.
`ifndef NOTE_ARPEGGIATOR_DEFINES_SVH
`define NOTE_ARPEGGIATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define ARP_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("note_arpeggiator: check failed");

`define ARP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("note_arpeggiator: check failed");

`define ARP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("note_arpeggiator: check failed");

`else

`define ARP_ASSERT(label, expr)
`define ARP_ASSERT_IMP(label, ante, cons)
`define ARP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/arp_pkg.sv */
// Types, constants and codes shared by the note arpeggiator modules.
`timescale 1ns / 1ps

package arp_pkg;

    localparam int NOTE_SLOTS  = 5;
    localparam int OCTAVES     = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam int CNT_W  = $clog2(NOTE_SLOTS + 1);
    localparam int SLOT_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int OCT_W  = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  SEMITONES       = 8'd12;
    localparam logic [15:0] DIVIDER_RESET   = 16'd24;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic EVT_STOP = 1'b0;
    localparam logic EVT_PLAY = 1'b1;

    localparam logic REG_TICK_DIVIDER = 1'b0;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] note;
    } arp_in_t;

    typedef struct packed {
        logic       event_kind;
        logic [7:0] out_note;
        logic       last;
    } arp_out_t;

    typedef struct packed {
        logic [CNT_W-1:0] held_count;
        logic             running;
        logic             sounding_valid;
    } arp_status_t;

endpackage

/* rtl/arp_front.sv */
// Front end: accepts command words, drops unused codes and queues the rest.
`timescale 1ns / 1ps

module arp_front
    import arp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_stall,
    input  arp_in_t cmd_word,
    output logic    q_valid,
    output arp_in_t q_item,
    input  logic    q_pop
);

    arp_in_t            queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  q_cnt_reg;
    logic [QCNT_W-1:0]  q_cnt_next;
    logic               accept;
    logic               push;
    logic               pop;

    assign cmd_stall = (q_cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept    = cmd_valid && !cmd_stall;
    assign push      = accept && (cmd_word.cmd != CMD_UNUSED);
    assign q_valid   = (q_cnt_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_item    = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            q_cnt_next = q_cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            q_cnt_next = q_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_word;
        end
    end

endmodule

/* rtl/arp_back.sv */
// Back end: held note list, step timing and the two-entry result buffer.
`timescale 1ns / 1ps

module arp_back
    import arp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  arp_in_t     q_item,
    output logic        q_pop,
    input  logic [15:0] tick_divider,
    input  logic        tick_clear,
    output logic        evt_valid,
    input  logic        evt_stall,
    output arp_out_t    evt_word,
    output arp_status_t status
);

    logic [6:0]       held_notes_reg  [NOTE_SLOTS];
    logic [6:0]       held_notes_next [NOTE_SLOTS];
    logic [CNT_W-1:0] held_count_reg;
    logic [CNT_W-1:0] held_count_next;
    logic [CNT_W-1:0] play_index_reg;
    logic [CNT_W-1:0] play_index_next;
    logic [OCT_W-1:0] octave_step_reg;
    logic [OCT_W-1:0] octave_step_next;
    logic [15:0]      tick_counter_reg;
    logic [15:0]      tick_counter_next;
    logic             running_reg;
    logic             running_next;
    logic [7:0]       sounding_note_reg;
    logic [7:0]       sounding_note_next;
    logic             sounding_valid_reg;
    logic             sounding_valid_next;

    arp_out_t         res_reg [2];
    arp_out_t         res_next [2];
    logic [1:0]       res_cnt_reg;
    logic [1:0]       res_cnt_next;

    logic             pop;
    logic             evt_accept;
    logic             list_full;
    logic             rm_found;
    logic [CNT_W-1:0] rm_pos;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_step;
    logic [OCT_W:0]   oct_inc;
    logic [OCT_W-1:0] oct_step;
    logic             wrap;
    logic [15:0]      tick_inc;
    logic [7:0]       play_note;

    assign q_pop      = (res_cnt_reg == 2'd0);
    assign pop        = q_pop && q_valid;
    assign evt_valid  = (res_cnt_reg != 2'd0);
    assign evt_accept = evt_valid && !evt_stall;
    assign evt_word   = res_reg[0];
    assign list_full  = (held_count_reg == CNT_W'(NOTE_SLOTS));

    assign status.held_count     = held_count_reg;
    assign status.running        = running_reg;
    assign status.sounding_valid = sounding_valid_reg;

    always_comb
    begin
        rm_found = 1'b0;
        rm_pos   = '0;
        for (int i = NOTE_SLOTS - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < held_count_reg) && (held_notes_reg[i] == q_item.note))
            begin
                rm_found = 1'b1;
                rm_pos   = CNT_W'(i);
            end
        end
    end

    always_comb
    begin
        idx_inc  = play_index_reg + 1'b1;
        wrap     = (idx_inc >= held_count_reg);
        idx_step = wrap ? '0 : idx_inc;
        oct_inc  = {1'b0, octave_step_reg} + 1'b1;
        if (!wrap)
        begin
            oct_step = octave_step_reg;
        end
        else if (oct_inc >= (OCT_W + 1)'(OCTAVES))
        begin
            oct_step = '0;
        end
        else
        begin
            oct_step = oct_inc[OCT_W-1:0];
        end
        play_note = {1'b0, held_notes_reg[idx_step[SLOT_W-1:0]]} + 8'(8'(oct_step) * SEMITONES);
        tick_inc  = tick_counter_reg + 16'd1;
    end

    always_comb
    begin
        for (int i = 0; i < NOTE_SLOTS; i++)
        begin
            held_notes_next[i] = held_notes_reg[i];
        end
        held_count_next     = held_count_reg;
        play_index_next     = play_index_reg;
        octave_step_next    = octave_step_reg;
        tick_counter_next   = tick_counter_reg;
        running_next        = running_reg;
        sounding_note_next  = sounding_note_reg;
        sounding_valid_next = sounding_valid_reg;
        res_next[0]         = res_reg[0];
        res_next[1]         = res_reg[1];
        res_cnt_next        = res_cnt_reg;

        if (pop)
        begin
            unique case (q_item.cmd)
                CMD_ADD:
                begin
                    for (int i = 0; i < NOTE_SLOTS; i++)
                    begin
                        if (list_full)
                        begin
                            held_notes_next[i] = (i < NOTE_SLOTS - 1) ?
                                                 held_notes_reg[(i + 1) % NOTE_SLOTS] : 7'd0;
                        end
                        if ((list_full && (i == NOTE_SLOTS - 1)) ||
                            (!list_full && (CNT_W'(i) == held_count_reg)))
                        begin
                            held_notes_next[i] = q_item.note;
                        end
                    end
                    held_count_next = list_full ? held_count_reg : held_count_reg + 1'b1;
                    if (!running_reg)
                    begin
                        tick_counter_next = '0;
                        running_next      = 1'b1;
                        octave_step_next  = '0;
                    end
                end
                CMD_REMOVE:
                begin
                    if (rm_found)
                    begin
                        for (int i = 0; i < NOTE_SLOTS; i++)
                        begin
                            if (CNT_W'(i) >= rm_pos)
                            begin
                                held_notes_next[i] = (i < NOTE_SLOTS - 1) ?
                                                     held_notes_reg[(i + 1) % NOTE_SLOTS] : 7'd0;
                            end
                        end
                        held_count_next = held_count_reg - 1'b1;
                        if (play_index_reg == held_count_reg - 1'b1)
                        begin
                            play_index_next = '0;
                        end
                        else if (play_index_reg > rm_pos)
                        begin
                            play_index_next = play_index_reg - 1'b1;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        if (tick_counter_reg == 16'd0)
                        begin
                            if (held_count_reg == '0)
                            begin
                                running_next        = 1'b0;
                                sounding_note_next  = 8'd0;
                                sounding_valid_next = 1'b0;
                                res_next[0] = '{event_kind: EVT_STOP,
                                                out_note: sounding_note_reg, last: 1'b1};
                                res_cnt_next = sounding_valid_reg ? 2'd1 : 2'd0;
                            end
                            else
                            begin
                                play_index_next     = idx_step;
                                octave_step_next    = oct_step;
                                sounding_note_next  = play_note;
                                sounding_valid_next = 1'b1;
                                if (sounding_valid_reg)
                                begin
                                    res_next[0] = '{event_kind: EVT_STOP,
                                                    out_note: sounding_note_reg, last: 1'b0};
                                    res_next[1] = '{event_kind: EVT_PLAY,
                                                    out_note: play_note, last: 1'b1};
                                    res_cnt_next = 2'd2;
                                end
                                else
                                begin
                                    res_next[0] = '{event_kind: EVT_PLAY,
                                                    out_note: play_note, last: 1'b1};
                                    res_cnt_next = 2'd1;
                                end
                            end
                        end
                        tick_counter_next = (tick_inc == tick_divider) ? 16'd0 : tick_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (evt_accept)
        begin
            res_next[0]  = res_reg[1];
            res_cnt_next = res_cnt_reg - 1'b1;
        end

        if (tick_clear)
        begin
            tick_counter_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NOTE_SLOTS; i++)
            begin
                held_notes_reg[i] <= '0;
            end
            held_count_reg     <= '0;
            play_index_reg     <= '0;
            octave_step_reg    <= '0;
            tick_counter_reg   <= '0;
            running_reg        <= 1'b0;
            sounding_note_reg  <= '0;
            sounding_valid_reg <= 1'b0;
            res_cnt_reg        <= 2'd0;
        end
        else
        begin
            for (int i = 0; i < NOTE_SLOTS; i++)
            begin
                held_notes_reg[i] <= held_notes_next[i];
            end
            held_count_reg     <= held_count_next;
            play_index_reg     <= play_index_next;
            octave_step_reg    <= octave_step_next;
            tick_counter_reg   <= tick_counter_next;
            running_reg        <= running_next;
            sounding_note_reg  <= sounding_note_next;
            sounding_valid_reg <= sounding_valid_next;
            res_cnt_reg        <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg[0] <= res_next[0];
        res_reg[1] <= res_next[1];
    end

endmodule

/* rtl/note_arpeggiator.sv */
// Note arpeggiator top level: register port, front end and back end.
//
// Command words (cmd, note) enter on the cmd channel: tick, add held note or
// remove held note. Event words (event_kind, out_note, last) leave on the evt
// channel; a step gives a stop word for the sounding note, a play word for the
// next note, or both, and last marks the final word of a command.
// A command word waits in a two-word queue, so the sender is stalled only when
// the queue is full; unused command codes are dropped at the door.
// The back end takes one command per cycle while its result buffer is empty.
// A command is written into the queue at the edge that accepts it and is applied
// when the back end pops it; its first event word is offered from then on.
// A tick that gives event words holds the back end until the evt channel has
// taken all of them, and a command that gives none does not hold it.
// Stalling the evt channel holds the buffered words and then fills the queue.
// The single register tick_divider sits at address 0; writing it clears the
// tick counter. Reset empties the note list, stops the arpeggio, sets the
// divider to 24 and discards all queued and buffered words.
`timescale 1ns / 1ps
`include "note_arpeggiator_defines.svh"

module note_arpeggiator
    import arp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  arp_in_t     cmd_word,
    output logic        evt_valid,
    input  logic        evt_stall,
    output arp_out_t    evt_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]  tick_divider_reg;
    logic         cfg_write;
    logic         q_valid;
    arp_in_t      q_item;
    logic         q_pop;
    arp_status_t  status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_TICK_DIVIDER);
    assign prdata    = (paddr[2] == REG_TICK_DIVIDER) ? {16'd0, tick_divider_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divider_reg <= DIVIDER_RESET;
        end
        else if (cfg_write)
        begin
            tick_divider_reg <= pwdata[15:0];
        end
    end

    arp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    arp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .tick_divider (tick_divider_reg),
        .tick_clear   (cfg_write),
        .evt_valid    (evt_valid),
        .evt_stall    (evt_stall),
        .evt_word     (evt_word),
        .status       (status)
    );

    `ARP_ASSERT(a_count_in_range, status.held_count <= CNT_W'(NOTE_SLOTS))
    `ARP_ASSERT_NEXT(a_follow_up_ready, evt_valid && !evt_stall && !evt_word.last, evt_valid)
    `ARP_ASSERT_IMP(a_play_while_running, evt_valid && (evt_word.event_kind == EVT_PLAY), status.running && status.sounding_valid)

endmodule

/* sim/note_arpeggiator_test.sv */
// Self-checking testbench for note_arpeggiator: a directed command table, then random words.
`timescale 1ns / 1ps
module note_arpeggiator_test;
    import arp_pkg::*;

    typedef struct packed {
        arp_in_t    word;
        logic       typed;
        logic [1:0] count;
        arp_out_t   first;
        arp_out_t   second;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    arp_in_t     cmd_word;
    logic        evt_valid;
    logic        evt_stall;
    arp_out_t    evt_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [6:0]  held_list [NOTE_SLOTS];
    int          held_total;
    int          step_pos;
    int          octave_pos;
    logic [15:0] tick_pos;
    logic [15:0] divider_val;
    bit          arp_on;
    bit          ring_on;
    logic [7:0]  ring_note;
    arp_out_t    step_events [2];

    arp_out_t    pending_events [$];
    arp_out_t    want_event;
    int          error_count;
    bit          calm;
    bit          rush;
    bit          hold_req;
    int          stall_left;
    int          free_left;
    script_row_t script [24];
    logic [15:0] phase_div [6];

    note_arpeggiator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_word (cmd_word),
        .evt_valid(evt_valid),
        .evt_stall(evt_stall),
        .evt_word (evt_word),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic arp_out_t mk_event(input logic kind, input logic [7:0] note,
                                          input logic last);
        arp_out_t e;
        e.event_kind = kind;
        e.out_note   = note;
        e.last       = last;
        return e;
    endfunction

    function automatic script_row_t mk_row(input logic [1:0] cmd, input logic [6:0] note,
                                           input logic typed, input logic [1:0] count,
                                           input arp_out_t first, input arp_out_t second);
        script_row_t r;
        r.word.cmd  = cmd;
        r.word.note = note;
        r.typed     = typed;
        r.count     = count;
        r.first     = first;
        r.second    = second;
        return r;
    endfunction

    // Applies one command word to the note list and returns how many events it causes.
    function automatic int arp_apply(input arp_in_t w);
        int n;
        int i;
        int j;
        int slot;
        n = 0;
        slot = -1;
        case (w.cmd)
            CMD_ADD:
            begin
                if (held_total >= NOTE_SLOTS)
                begin
                    for (i = 1; i < NOTE_SLOTS; i++)
                        held_list[i - 1] = held_list[i];
                    held_list[NOTE_SLOTS - 1] = '0;
                    held_total = NOTE_SLOTS - 1;
                end
                held_list[held_total] = w.note;
                held_total++;
                if (!arp_on)
                begin
                    tick_pos = '0;
                    arp_on = 1'b1;
                    octave_pos = 0;
                end
            end
            CMD_REMOVE:
            begin
                for (i = 0; i < held_total; i++)
                    if (slot < 0 && held_list[i] == w.note)
                        slot = i;
                if (slot >= 0)
                begin
                    for (j = slot + 1; j < NOTE_SLOTS; j++)
                        held_list[j - 1] = held_list[j];
                    held_list[NOTE_SLOTS - 1] = '0;
                    held_total--;
                    if (step_pos == held_total)
                        step_pos = 0;
                    else if (step_pos > slot)
                        step_pos--;
                end
            end
            CMD_TICK:
            begin
                if (arp_on)
                begin
                    if (tick_pos == 16'd0)
                    begin
                        if (ring_on)
                        begin
                            step_events[n] = mk_event(EVT_STOP, ring_note, 1'b0);
                            n++;
                        end
                        if (held_total == 0)
                        begin
                            arp_on = 1'b0;
                            ring_note = '0;
                            ring_on = 1'b0;
                        end
                        else
                        begin
                            step_pos++;
                            if (step_pos >= held_total)
                            begin
                                step_pos = 0;
                                octave_pos++;
                                if (octave_pos >= OCTAVES)
                                    octave_pos = 0;
                            end
                            ring_note = {1'b0, held_list[step_pos]} + SEMITONES * 8'(octave_pos);
                            ring_on = 1'b1;
                            step_events[n] = mk_event(EVT_PLAY, ring_note, 1'b0);
                            n++;
                        end
                    end
                    tick_pos = tick_pos + 16'd1;
                    if (tick_pos == divider_val)
                        tick_pos = '0;
                    if (n > 0)
                        step_events[n - 1].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return n;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm || rush)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Mostly well-formed traffic: ticks, adds, and removes of notes that are held.
    function automatic arp_in_t random_word();
        arp_in_t w;
        int r;
        r = $urandom_range(0, 99);
        w.note = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 9) == 0)
            w.note = ($urandom_range(0, 1) == 1) ? 7'd127 : 7'd0;
        if (held_total == 0 && r < 60)
            w.cmd = CMD_ADD;
        else if (r < 50)
            w.cmd = CMD_TICK;
        else if (r < 72)
            w.cmd = CMD_ADD;
        else if (r < 96)
        begin
            w.cmd = CMD_REMOVE;
            if (held_total > 0 && $urandom_range(0, 9) < 8)
                w.note = held_list[$urandom_range(0, held_total - 1)];
        end
        else
            w.cmd = CMD_UNUSED;
        return w;
    endfunction

    task automatic send_row(input script_row_t r);
        int gap;
        int n;
        int i;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= r.word;
        do @(posedge clk); while (cmd_stall);
        n = arp_apply(r.word);
        if (r.typed)
        begin
            if (r.count > 0)
                pending_events.push_back(r.first);
            if (r.count > 1)
                pending_events.push_back(r.second);
        end
        else
        begin
            for (i = 0; i < n; i++)
                pending_events.push_back(step_events[i]);
        end
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Optionally writes the divider, then reads it back.
    task automatic program_divider(input logic [15:0] value, input bit do_write);
        paddr <= 3'(4 * REG_TICK_DIVIDER);
        if (do_write)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            pwdata  <= 32'(value);
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            divider_val = value;
            tick_pos = '0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        else
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== 32'(divider_val))
            report($sformatf("tick_divider read %0d, want %0d", prdata, divider_val));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        evt_stall <= 1'b0;
        stall_left = 0;
        free_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = 200;
            end
            if (stall_left > 0)
            begin
                evt_stall <= 1'b1;
                stall_left--;
            end
            else if (calm || free_left > 0)
            begin
                evt_stall <= 1'b0;
                if (free_left > 0)
                    free_left--;
            end
            else
            begin
                evt_stall <= 1'b0;
                case ($urandom_range(0, 19))
                    0:       stall_left = $urandom_range(30, 80);
                    1, 2, 3: stall_left = $urandom_range(4, 10);
                    default: stall_left = $urandom_range(1, 3);
                endcase
                free_left = $urandom_range(0, 15);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (pending_events.size() == 0)
                report($sformatf("unexpected event word kind %0d note %0d last %0d",
                                 evt_word.event_kind, evt_word.out_note, evt_word.last));
            else
            begin
                want_event = pending_events.pop_front();
                if (evt_word.event_kind !== want_event.event_kind)
                    report($sformatf("event_kind %0d, want %0d",
                                     evt_word.event_kind, want_event.event_kind));
                if (evt_word.out_note !== want_event.out_note)
                    report($sformatf("out_note %0d, want %0d",
                                     evt_word.out_note, want_event.out_note));
                if (evt_word.last !== want_event.last)
                    report($sformatf("last %0d, want %0d", evt_word.last, want_event.last));
            end
        end
    end

    initial
    begin
        int i;
        int p;
        int k;
        arp_in_t rand_word;
        rst_n = 1'b0;
        cmd_valid <= 1'b0;
        cmd_word  <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        error_count = 0;
        calm = 1'b0;
        rush = 1'b0;
        hold_req = 1'b0;
        for (i = 0; i < NOTE_SLOTS; i++)
            held_list[i] = '0;
        held_total = 0;
        step_pos = 0;
        octave_pos = 0;
        tick_pos = '0;
        divider_val = DIVIDER_RESET;
        arp_on = 1'b0;
        ring_on = 1'b0;
        ring_note = '0;

        script[0]  = mk_row(CMD_TICK,   7'd0,   1'b1, 2'd0, '0, '0);
        script[1]  = mk_row(CMD_UNUSED, 7'd127, 1'b1, 2'd0, '0, '0);
        script[2]  = mk_row(CMD_ADD,    7'd0,   1'b1, 2'd0, '0, '0);
        script[3]  = mk_row(CMD_TICK,   7'd0,   1'b1, 2'd1,
                            mk_event(EVT_PLAY, 8'd12, 1'b1), '0);
        script[4]  = mk_row(CMD_TICK,   7'd0,   1'b1, 2'd2, mk_event(EVT_STOP, 8'd12, 1'b0),
                            mk_event(EVT_PLAY, 8'd24, 1'b1));
        script[5]  = mk_row(CMD_TICK,   7'd0,   1'b1, 2'd2, mk_event(EVT_STOP, 8'd24, 1'b0),
                            mk_event(EVT_PLAY, 8'd0, 1'b1));
        script[6]  = mk_row(CMD_ADD,    7'd127, 1'b1, 2'd0, '0, '0);
        script[7]  = mk_row(CMD_TICK,   7'd0,   1'b1, 2'd2, mk_event(EVT_STOP, 8'd0, 1'b0),
                            mk_event(EVT_PLAY, 8'd127, 1'b1));
        script[8]  = mk_row(CMD_ADD,    7'd1,   1'b1, 2'd0, '0, '0);
        script[9]  = mk_row(CMD_ADD,    7'd2,   1'b1, 2'd0, '0, '0);
        script[10] = mk_row(CMD_ADD,    7'd3,   1'b1, 2'd0, '0, '0);
        script[11] = mk_row(CMD_ADD,    7'd5,   1'b1, 2'd0, '0, '0);
        script[12] = mk_row(CMD_TICK,   7'd0,   1'b0, 2'd0, '0, '0);
        script[13] = mk_row(CMD_REMOVE, 7'd99,  1'b1, 2'd0, '0, '0);
        script[14] = mk_row(CMD_REMOVE, 7'd127, 1'b1, 2'd0, '0, '0);
        script[15] = mk_row(CMD_ADD,    7'd1,   1'b1, 2'd0, '0, '0);
        script[16] = mk_row(CMD_REMOVE, 7'd1,   1'b1, 2'd0, '0, '0);
        script[17] = mk_row(CMD_TICK,   7'd85,  1'b0, 2'd0, '0, '0);
        script[18] = mk_row(CMD_REMOVE, 7'd2,   1'b1, 2'd0, '0, '0);
        script[19] = mk_row(CMD_REMOVE, 7'd3,   1'b1, 2'd0, '0, '0);
        script[20] = mk_row(CMD_REMOVE, 7'd5,   1'b1, 2'd0, '0, '0);
        script[21] = mk_row(CMD_REMOVE, 7'd1,   1'b1, 2'd0, '0, '0);
        script[22] = mk_row(CMD_TICK,   7'd42,  1'b0, 2'd0, '0, '0);
        script[23] = mk_row(CMD_TICK,   7'd0,   1'b1, 2'd0, '0, '0);

        phase_div[0] = 16'd1;
        phase_div[1] = 16'd2;
        phase_div[2] = 16'd65535;
        phase_div[3] = 16'd1;
        phase_div[4] = 16'd3;
        phase_div[5] = 16'd7;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        program_divider(DIVIDER_RESET, 1'b0);
        program_divider(16'd1, 1'b1);
        for (i = 0; i < 24; i++)
            send_row(script[i]);

        for (p = 0; p < 6; p++)
        begin
            settle();
            program_divider(phase_div[p], 1'b1);
            calm = (p == 3);
            if (p == 1)
            begin
                hold_req = 1'b1;
                rush = 1'b1;
            end
            for (k = 0; k < 100; k++)
            begin
                if (p == 1 && k == 40)
                    rush = 1'b0;
                if (p == 4 && k == 50)
                    settle();
                rand_word = random_word();
                send_row(mk_row(rand_word.cmd, rand_word.note, 1'b0, 2'd0, '0, '0));
            end
            calm = 1'b0;
        end

        cmd_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
